// ===== hdl/grl_pkg.sv =====
package grl_pkg;

    localparam int W_RD   = 32;
    localparam int W_PCT  = 15;
    localparam int W_WH   = 7;
    localparam int W_LVL  = 2;
    localparam int W_EXT  = 36;
    localparam int W_NUM  = 33;
    localparam int W_SPAN = 14;
    localparam int W_PROD = W_NUM + W_SPAN;
    localparam int W_IDX  = 3;
    localparam int QDEPTH_DEF = 4;

    localparam logic [W_PCT-1:0] PCT_0   = 15'd0;
    localparam logic [W_PCT-1:0] PCT_33  = 15'd8448;
    localparam logic [W_PCT-1:0] PCT_66  = 15'd16896;
    localparam logic [W_PCT-1:0] PCT_100 = 15'd25600;

    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_BAND = 2'd2;

    localparam logic [W_LVL-1:0] LVL_NORMAL  = 2'd0;
    localparam logic [W_LVL-1:0] LVL_WARNING = 2'd1;
    localparam logic [W_LVL-1:0] LVL_ALARM   = 2'd2;

    localparam logic [W_IDX-1:0] CFG_MODE        = 3'd0;
    localparam logic [W_IDX-1:0] CFG_CHART_MIN   = 3'd1;
    localparam logic [W_IDX-1:0] CFG_ALARM_LOW   = 3'd2;
    localparam logic [W_IDX-1:0] CFG_NORMAL_LOW  = 3'd3;
    localparam logic [W_IDX-1:0] CFG_NORMAL_HIGH = 3'd4;
    localparam logic [W_IDX-1:0] CFG_ALARM_HIGH  = 3'd5;
    localparam logic [W_IDX-1:0] CFG_CHART_MAX   = 3'd6;
    localparam logic [W_IDX-1:0] CFG_ALARM_EQ    = 3'd7;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [W_RD-1:0] chart_lo;
        logic signed [W_RD-1:0] alarm_lo;
        logic signed [W_RD-1:0] norm_lo;
        logic signed [W_RD-1:0] norm_hi;
        logic signed [W_RD-1:0] alarm_hi;
        logic signed [W_RD-1:0] chart_hi;
        logic                   alarm_at_equal;
    } t_cfg;

    // One classified reading on its way to the divider.
    typedef struct packed {
        logic              hold;
        logic              fix;
        logic [W_LVL-1:0]  lvl;
        logic [W_PCT-1:0]  fix_val;
        logic [W_PCT-1:0]  low;
        logic [W_SPAN-1:0] span;
        logic [W_NUM-1:0]  num;
        logic [W_NUM-1:0]  den;
    } t_job;

    function automatic logic signed [W_EXT-1:0] sx(input logic [W_RD-1:0] v);
        return {{(W_EXT-W_RD){v[W_RD-1]}}, v};
    endfunction

endpackage

// ===== hdl/grl_in_if.sv =====
interface grl_in_if
    import grl_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic signed [W_RD-1:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

// ===== hdl/grl_out_if.sv =====
interface grl_out_if
    import grl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [W_PCT-1:0] hazard_pct;
    logic [W_WH-1:0]  danger_whole;
    logic [W_LVL-1:0] risk_level;

    modport source (output valid, output hazard_pct, output danger_whole,
                    output risk_level, input ready);
    modport sink   (input valid, input hazard_pct, input danger_whole,
                    input risk_level, output ready);
endinterface

// ===== hdl/grl_front.sv =====
module grl_front
    import grl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [W_RD-1:0] i_reading,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_job                   o_job
);

    logic r_v;
    t_job r_job;
    t_job n_job;

    always_comb begin
        logic signed [W_EXT-1:0] r, cm, al, nl, nh, ah, cx, c2, r2, num, den;
        logic [W_PCT-1:0] lo, hi;
        logic alarm;
        r  = sx(i_reading);
        cm = sx(i_cfg.chart_lo);
        al = sx(i_cfg.alarm_lo);
        nl = sx(i_cfg.norm_lo);
        nh = sx(i_cfg.norm_hi);
        ah = sx(i_cfg.alarm_hi);
        cx = sx(i_cfg.chart_hi);
        c2 = nl + nh;
        r2 = r <<< 1;
        num = '0;
        den = '0;
        lo = PCT_0;
        hi = PCT_33;
        alarm = i_cfg.alarm_at_equal ? (r >= ah) : (r > ah);
        n_job = '0;
        n_job.hold = (i_cfg.mode != MODE_HIGH) && (i_cfg.mode != MODE_BAND);
        if (i_cfg.mode == MODE_HIGH) begin
            if (r <= nh) begin
                n_job.lvl = LVL_NORMAL;
                num = r - cm; den = nh - cm; lo = PCT_0; hi = PCT_33;
            end else if (!alarm) begin
                n_job.lvl = LVL_WARNING;
                num = r - nh; den = ah - nh; lo = PCT_33; hi = PCT_66;
            end else begin
                n_job.lvl = LVL_ALARM;
                num = r - ah; den = cx - ah; lo = PCT_66; hi = PCT_100;
                // A chart that ends at or below the alarm threshold reads full scale.
                if (cx <= ah) begin
                    num = 36'sd1; den = 36'sd1;
                end
            end
        end else begin
            if (r >= nl && r <= nh) begin
                n_job.lvl = LVL_NORMAL;
                lo = PCT_0; hi = PCT_33;
                if (r2 <= c2) begin
                    num = c2 - r2; den = c2 - (nl <<< 1);
                end else begin
                    num = r2 - c2; den = (nh <<< 1) - c2;
                end
            end else if (r >= al && r <= ah) begin
                n_job.lvl = LVL_WARNING;
                lo = PCT_33; hi = PCT_66;
                if (r < nl) begin
                    num = nl - r; den = nl - al;
                end else begin
                    num = r - nh; den = ah - nh;
                end
            end else begin
                n_job.lvl = LVL_ALARM;
                lo = PCT_66; hi = PCT_100;
                if (r < al) begin
                    num = al - r; den = al - cm;
                end else begin
                    num = r - ah; den = cx - ah;
                end
            end
        end
        n_job.low  = lo;
        n_job.span = W_SPAN'(hi - lo);
        n_job.num  = num[W_NUM-1:0];
        n_job.den  = den[W_NUM-1:0];
        if (den <= 0 || num <= 0) begin
            n_job.fix = 1'b1; n_job.fix_val = lo;
        end else if (num >= den) begin
            n_job.fix = 1'b1; n_job.fix_val = hi;
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== hdl/grl_queue.sv =====
module grl_queue
    import grl_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== hdl/grl_back.sv =====
module grl_back
    import grl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    grl_out_if.source o_out
);

    localparam int NS = W_SPAN + 1;

    logic              r_v   [NS];
    t_job              r_job [NS];
    logic [W_PROD-1:0] r_rem [NS];
    logic [W_SPAN-1:0] r_q   [NS];
    logic              r_ov;
    logic [W_PCT-1:0]  r_pct;
    logic [W_LVL-1:0]  r_lvl;
    logic [W_PCT-1:0]  r_hp;
    logic [W_LVL-1:0]  r_hl;
    logic              en;
    logic [W_PCT-1:0]  n_pct;
    logic [W_LVL-1:0]  n_lvl;

    assign en      = !r_ov || o_out.ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
        if (en) begin
            r_job[0] <= i_job;
            r_rem[0] <= W_PROD'(i_job.num) * W_PROD'(i_job.span);
            r_q[0]   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar s = 0; s < W_SPAN; s++) begin : g_div
        localparam int B = W_SPAN - 1 - s;
        logic [W_PROD-1:0] sh;
        logic              ge;
        assign sh = W_PROD'(r_job[s].den) << B;
        assign ge = (r_rem[s] >= sh);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (en) begin
                r_v[s+1] <= r_v[s];
            end
            if (en) begin
                r_job[s+1] <= r_job[s];
                r_rem[s+1] <= ge ? r_rem[s] - sh : r_rem[s];
                r_q[s+1]   <= r_q[s] | (ge ? W_SPAN'(1) << B : '0);
            end
        end
    end

    always_comb begin
        if (r_job[NS-1].hold) begin
            n_pct = r_hp;
            n_lvl = r_hl;
        end else begin
            n_pct = r_job[NS-1].fix ? r_job[NS-1].fix_val
                                    : r_job[NS-1].low + W_PCT'(r_q[NS-1]);
            n_lvl = r_job[NS-1].lvl;
        end
    end

    // The held result follows the items in order, so a hold item sees its predecessor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_hp <= PCT_0;
            r_hl <= LVL_NORMAL;
        end else if (en) begin
            r_ov <= r_v[NS-1];
            if (r_v[NS-1]) begin
                r_hp <= n_pct;
                r_hl <= n_lvl;
            end
        end
        if (en && r_v[NS-1]) begin
            r_pct <= n_pct;
            r_lvl <= n_lvl;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.hazard_pct   = r_pct;
    assign o_out.danger_whole = r_pct[W_PCT-1:8];
    assign o_out.risk_level   = r_lvl;

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_pct <= PCT_100))
        else $error("danger percent out of range");

    a_quot_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !r_job[NS-1].fix && !r_job[NS-1].hold)
            |-> (r_q[NS-1] < r_job[NS-1].span))
        else $error("quotient reached segment span");

    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_hp == r_pct && r_hl == r_lvl))
        else $error("held result differs from shown result");

endmodule

// ===== hdl/gas_risk_level_mapper_unit.sv =====
// An accepted reading passes in order through the classify register, the queue,
// the multiply stage, 14 divide stages and the output register to a valid result.
// One reading per cycle unless output stalls; pipelined divider has no feedback.
// Reset (i_rst_n low, synchronous) clears the configuration registers to zero,
// empties the pipeline and sets the held result to zero percent, level normal.
module gas_risk_level_mapper_unit
    import grl_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [W_IDX-1:0] i_cfg_idx,
    input  logic [W_RD-1:0]  i_cfg_data,
    grl_in_if.sink           i_in,
    grl_out_if.source        o_out
);

    t_cfg r_cfg;
    logic f_valid, f_ready, q_valid, q_ready;
    t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:        r_cfg.mode <= i_cfg_data[1:0];
                CFG_CHART_MIN:   r_cfg.chart_lo <= i_cfg_data;
                CFG_ALARM_LOW:   r_cfg.alarm_lo <= i_cfg_data;
                CFG_NORMAL_LOW:  r_cfg.norm_lo <= i_cfg_data;
                CFG_NORMAL_HIGH: r_cfg.norm_hi <= i_cfg_data;
                CFG_ALARM_HIGH:  r_cfg.alarm_hi <= i_cfg_data;
                CFG_CHART_MAX:   r_cfg.chart_hi <= i_cfg_data;
                CFG_ALARM_EQ:    r_cfg.alarm_at_equal <= i_cfg_data[0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    grl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_reading (i_in.reading),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_job     (f_job)
    );

    grl_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    grl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_out   (o_out)
    );

endmodule

// ===== verif/tb_gas_risk_level_mapper_unit.sv =====
module tb_gas_risk_level_mapper_unit;
    import grl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [W_PCT-1:0] pct;
        logic [W_WH-1:0]  whole;
        logic [W_LVL-1:0] lvl;
    } t_risk;

    // One row of the directed table; known marks a result typed in by hand.
    typedef struct {
        logic signed [W_RD-1:0] reading;
        bit                     known;
        t_risk                  res;
    } t_row;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [W_IDX-1:0] cfg_idx;
    logic [W_RD-1:0]  cfg_data;

    grl_in_if  in_ch();
    grl_out_if out_ch();

    gas_risk_level_mapper_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Mirror of the block's configuration and held result.
    logic [1:0]         m_mode;
    longint             m_cmin, m_alow, m_nlow, m_nhigh, m_ahigh, m_cmax;
    bit                 m_aeq;
    logic [W_PCT-1:0]   held_pct;
    logic [W_LVL-1:0]   held_lvl;

    t_risk  risk_q[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     n_lvl[3] = '{0, 0, 0};
    bit     stall_long = 0;
    bit     out_free = 1;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #100ms;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint scale_segment(longint num, longint den, longint lo,
                                             longint hi);
        if (den <= 0 || num <= 0) return lo;
        if (num >= den) return hi;
        return lo + (num * (hi - lo)) / den;
    endfunction

    function automatic t_risk map_reading(logic signed [W_RD-1:0] rd);
        longint r, c2, r2, p;
        logic [W_LVL-1:0] l;
        t_risk t;
        r = rd;
        p = held_pct;
        l = held_lvl;
        if (m_mode == MODE_HIGH) begin
            if (r <= m_nhigh) begin
                l = LVL_NORMAL;
                p = scale_segment(r - m_cmin, m_nhigh - m_cmin, PCT_0, PCT_33);
            end else if (m_aeq ? (r < m_ahigh) : (r <= m_ahigh)) begin
                l = LVL_WARNING;
                p = scale_segment(r - m_nhigh, m_ahigh - m_nhigh, PCT_33, PCT_66);
            end else begin
                l = LVL_ALARM;
                p = (m_cmax <= m_ahigh) ? longint'(PCT_100) :
                    scale_segment(r - m_ahigh, m_cmax - m_ahigh, PCT_66, PCT_100);
            end
        end else if (m_mode == MODE_BAND) begin
            c2 = m_nlow + m_nhigh;
            r2 = 2 * r;
            if (r >= m_nlow && r <= m_nhigh) begin
                l = LVL_NORMAL;
                p = (r2 <= c2) ? scale_segment(c2 - r2, c2 - 2 * m_nlow, PCT_0, PCT_33)
                               : scale_segment(r2 - c2, 2 * m_nhigh - c2, PCT_0, PCT_33);
            end else if (r >= m_alow && r <= m_ahigh) begin
                l = LVL_WARNING;
                p = (r < m_nlow) ?
                    scale_segment(m_nlow - r, m_nlow - m_alow, PCT_33, PCT_66) :
                    scale_segment(r - m_nhigh, m_ahigh - m_nhigh, PCT_33, PCT_66);
            end else begin
                l = LVL_ALARM;
                p = (r < m_alow) ?
                    scale_segment(m_alow - r, m_alow - m_cmin, PCT_66, PCT_100) :
                    scale_segment(r - m_ahigh, m_cmax - m_ahigh, PCT_66, PCT_100);
            end
        end
        if (p > PCT_100) p = PCT_100;
        t.pct = p[W_PCT-1:0];
        t.whole = t.pct[W_PCT-1:8];
        t.lvl = l;
        held_pct = t.pct;
        held_lvl = l;
        return t;
    endfunction

    task automatic write_reg(logic [W_IDX-1:0] idx, logic [W_RD-1:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            CFG_MODE:        m_mode = val[1:0];
            CFG_CHART_MIN:   m_cmin = longint'(signed'(val));
            CFG_ALARM_LOW:   m_alow = longint'(signed'(val));
            CFG_NORMAL_LOW:  m_nlow = longint'(signed'(val));
            CFG_NORMAL_HIGH: m_nhigh = longint'(signed'(val));
            CFG_ALARM_HIGH:  m_ahigh = longint'(signed'(val));
            CFG_CHART_MAX:   m_cmax = longint'(signed'(val));
            default:         m_aeq = val[0];
        endcase
    endtask

    task automatic set_chart(logic [1:0] md, int cmin, int alow, int nlow, int nhigh,
                             int ahigh, int cmax, bit aeq);
        write_reg(CFG_MODE, W_RD'(md));
        write_reg(CFG_CHART_MIN, cmin);
        write_reg(CFG_ALARM_LOW, alow);
        write_reg(CFG_NORMAL_LOW, nlow);
        write_reg(CFG_NORMAL_HIGH, nhigh);
        write_reg(CFG_ALARM_HIGH, ahigh);
        write_reg(CFG_CHART_MAX, cmax);
        write_reg(CFG_ALARM_EQ, W_RD'(aeq));
    endtask

    // Stops offering, waits for every expected beat, then lets the pipeline drain.
    task automatic drain();
        in_ch.valid <= 0;
        while (risk_q.size() != 0) @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    // Leaves valid high after the beat so that the next call can follow with no gap.
    task automatic send_reading(logic signed [W_RD-1:0] rd, bit use_gap);
        int gap;
        gap = use_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        repeat (gap) begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.reading <= rd;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        risk_q.push_back(map_reading(rd));
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [W_RD-1:0] pick_reading();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return m_nlow[31:0];
            4: return m_nhigh[31:0];
            5: return m_ahigh[31:0];
            6: return m_alow[31:0];
            default: return m_cmin[31:0] + $urandom_range(0, 32'h0fffffff);
        endcase
    endfunction

    task automatic random_chart();
        int v[6];
        int t;
        for (int i = 0; i < 6; i++) v[i] = $urandom;
        // Mostly ordered thresholds; otherwise leave them scrambled.
        if ($urandom_range(0, 4) != 0) begin
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 5 - i; j++)
                    if (v[j] > v[j + 1]) begin
                        t = v[j];
                        v[j] = v[j + 1];
                        v[j + 1] = t;
                    end
        end
        set_chart(2'($urandom_range(0, 3)), v[0], v[1], v[2], v[3], v[4], v[5],
                  1'($urandom_range(0, 1)));
    endtask

    // Receiver: random stalls, plus one long hold-off when asked.
    initial begin
        int stall;
        out_ch.ready = 0;
        @(negedge clk);
        forever begin
            if (stall_long) begin
                out_ch.ready <= 0;
                repeat (300) @(negedge clk);
                stall_long = 0;
            end
            stall = out_free ? 0 :
                    (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
            if (stall != 0) begin
                out_ch.ready <= 0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        t_risk w;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            n_got++;
            if (risk_q.size() == 0) begin
                $display("%0t: unexpected beat pct=%0d", $time, out_ch.hazard_pct);
                errors++;
            end else begin
                w = risk_q.pop_front();
                n_lvl[w.lvl]++;
                if (out_ch.hazard_pct !== w.pct) begin
                    $display("%0t: percent exp %0d got %0d", $time, w.pct,
                             out_ch.hazard_pct);
                    errors++;
                end
                if (out_ch.danger_whole !== w.whole) begin
                    $display("%0t: whole exp %0d got %0d", $time, w.whole,
                             out_ch.danger_whole);
                    errors++;
                end
                if (out_ch.risk_level !== w.lvl) begin
                    $display("%0t: level exp %0d got %0d", $time, w.lvl,
                             out_ch.risk_level);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_risk got;
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = CFG_MODE;
        cfg_data = 0;
        in_ch.valid = 0;
        in_ch.reading = 0;
        m_mode = 0; m_cmin = 0; m_alow = 0; m_nlow = 0; m_nhigh = 0;
        m_ahigh = 0; m_cmax = 0; m_aeq = 0;
        held_pct = 0; held_lvl = LVL_NORMAL;
        repeat (6) @(negedge clk);
        rst_n = 1;

        // Mode none right after reset repeats zero percent, normal.
        rows.push_back('{32'sh7fffffff, 1, '{PCT_0, 0, LVL_NORMAL}});
        rows.push_back('{32'sh80000000, 1, '{PCT_0, 0, LVL_NORMAL}});
        foreach (rows[i]) begin
            got = '{rows[i].res.pct, rows[i].res.whole, rows[i].res.lvl};
            send_reading(rows[i].reading, 0);
            if (rows[i].known && risk_q[$] != got) begin
                $display("%0t: table row %0d predictor exp %0d got %0d", $time, i,
                         got.pct, risk_q[$].pct);
                errors++;
            end
        end
        drain();

        // High mode, chart 0..300, normal 100, alarm 200, compare strict.
        set_chart(MODE_HIGH, 0, 0, 0, 100 << 16, 200 << 16, 300 << 16, 0);
        rows.delete();
        rows.push_back('{32'sh80000000, 1, '{PCT_0, 0, LVL_NORMAL}});
        rows.push_back('{100 << 16, 1, '{PCT_33, 33, LVL_NORMAL}});
        rows.push_back('{200 << 16, 1, '{PCT_66, 66, LVL_WARNING}});
        rows.push_back('{32'sh7fffffff, 1, '{PCT_100, 100, LVL_ALARM}});
        rows.push_back('{150 << 16, 0, '{0, 0, 0}});
        rows.push_back('{250 << 16, 0, '{0, 0, 0}});
        rows.push_back('{33, 0, '{0, 0, 0}});
        foreach (rows[i]) begin
            got = rows[i].res;
            send_reading(rows[i].reading, 0);
            if (rows[i].known && risk_q[$] != got) begin
                $display("%0t: table row %0d predictor exp %0d got %0d", $time, i,
                         got.pct, risk_q[$].pct);
                errors++;
            end
        end
        drain();
        // Inclusive alarm; chart max below alarm gives full scale.
        set_chart(MODE_HIGH, 0, 0, 0, 100 << 16, 200 << 16, 150 << 16, 1);
        send_reading(200 << 16, 0);
        send_reading(199 << 16, 0);
        drain();
        // Band mode with center, edges, and degenerate segments.
        set_chart(MODE_BAND, -300 << 16, -200 << 16, -100 << 16, 100 << 16,
                  200 << 16, 200 << 16, 0);
        send_reading(0, 0);
        send_reading(1, 0);
        send_reading(-1, 0);
        send_reading(100 << 16, 0);
        send_reading(-100 << 16, 0);
        send_reading(-150 << 16, 0);
        send_reading(150 << 16, 0);
        send_reading(201 << 16, 0);
        send_reading(-250 << 16, 0);
        send_reading(32'sh80000000, 0);
        send_reading(32'sh7fffffff, 0);
        drain();
        // Unused mode holds the last result.
        write_reg(CFG_MODE, 32'd3);
        send_reading(12345, 0);
        drain();
        // Extremes of every register.
        set_chart(MODE_HIGH, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1);
        send_reading(0, 0);
        send_reading(32'sh7fffffff, 0);
        drain();
        set_chart(MODE_BAND, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_reading(32'sh80000000, 0);
        send_reading(32'sh7fffffff, 0);
        drain();

        // Fill the block while the receiver holds off.
        out_free = 0;
        stall_long = 1;
        for (int i = 0; i < 40; i++) send_reading(pick_reading(), 0);
        drain();

        while (n_sent < 1250) begin
            random_chart();
            for (int i = 0; i < 100; i++) send_reading(pick_reading(), 1);
            drain();
        end

        if (errors == 0) begin
            $display("%0d readings sent, %0d results checked", n_sent, n_got);
            $display("levels seen: normal %0d, warning %0d, alarm %0d",
                     n_lvl[0], n_lvl[1], n_lvl[2]);
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches over %0d results", errors, n_got);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/grl_pkg.sv
hdl/grl_in_if.sv
hdl/grl_out_if.sv
hdl/grl_front.sv
hdl/grl_queue.sv
hdl/grl_back.sv
hdl/gas_risk_level_mapper_unit.sv
verif/tb_gas_risk_level_mapper_unit.sv
